// File: design/sllm_pkg.sv
`timescale 1ns / 1ps

package sllm_pkg;

    localparam int NODES = 32;
    localparam int ID_W  = 5;
    localparam int CNT_W = 6;
    localparam int SP_W  = (NODES > 2) ? $clog2(NODES - 1) : 1;

    typedef enum logic [2:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_DELETE    = 3'd4,
        OP_INSERT    = 3'd5,
        OP_CONTAINS  = 3'd6,
        OP_SIZE      = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        CA_HOLD,
        CA_MARK,
        CA_SPREAD,
        CA_SHIFT_IN,
        CA_SHIFT_OUT,
        CA_FILL,
        CA_DROP,
        CA_CLOSE,
        CA_OPEN
    } cell_act_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
        logic            mark;
    } cell_data_t;

    typedef struct packed {
        cell_act_t act;
        logic      mark_ref;
    } cell_ctl_t;

endpackage

// File: design/sllm_cell.sv
`timescale 1ns / 1ps

module sllm_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sllm_pkg::cell_ctl_t          ctl,
    input  logic [sllm_pkg::ID_W-1:0]    q_node,
    input  logic [sllm_pkg::ID_W-1:0]    q_ref,
    input  sllm_pkg::cell_data_t         left_i,
    input  sllm_pkg::cell_data_t         right_i,
    output sllm_pkg::cell_data_t         cell_o,
    output logic                         hit_node_o,
    output logic                         hit_ref_o
);
    import sllm_pkg::*;

    cell_data_t cell_reg;
    cell_data_t cell_next;

    assign cell_o     = cell_reg;
    assign hit_node_o = cell_reg.valid && (cell_reg.id == q_node);
    assign hit_ref_o  = cell_reg.valid && (cell_reg.id == q_ref);

    always_comb begin
        cell_next = cell_reg;
        unique case (ctl.act)
            CA_HOLD: begin
            end
            CA_MARK: begin
                cell_next.mark = ctl.mark_ref ? hit_ref_o : hit_node_o;
            end
            CA_SPREAD: begin
                // mark ripples one cell per cycle toward the tail
                cell_next.mark = cell_reg.mark | left_i.mark;
            end
            CA_SHIFT_IN: begin
                cell_next.valid = left_i.valid;
                cell_next.id    = left_i.id;
            end
            CA_SHIFT_OUT: begin
                cell_next.valid = right_i.valid;
                cell_next.id    = right_i.id;
            end
            CA_FILL: begin
                if (!cell_reg.valid && left_i.valid) begin
                    cell_next.valid = 1'b1;
                    cell_next.id    = q_node;
                end
            end
            CA_DROP: begin
                if (cell_reg.valid && !right_i.valid) begin
                    cell_next.valid = 1'b0;
                end
            end
            CA_CLOSE: begin
                if (cell_reg.mark) begin
                    cell_next.valid = right_i.valid;
                    cell_next.id    = right_i.id;
                end
                cell_next.mark = 1'b0;
            end
            CA_OPEN: begin
                // first marked cell holds the reference node; new node goes there
                if (cell_reg.mark) begin
                    if (!left_i.mark) begin
                        cell_next.valid = 1'b1;
                        cell_next.id    = q_node;
                    end else begin
                        cell_next.valid = left_i.valid;
                        cell_next.id    = left_i.id;
                    end
                end
                cell_next.mark = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
            cell_reg.mark  <= 1'b0;
            cell_reg.id    <= '0;
        end else begin
            cell_reg <= cell_next;
        end
    end

endmodule

// File: design/singly_linked_list_manager.sv
`timescale 1ns / 1ps

// Ordered list of node ids kept in a row of NODES cells, head in cell 0. Each request
// is one 16-bit item; each gives exactly one result item. Delete and insert-before take
// longer than the other requests because the position mark ripples one cell per cycle
// down the row before the cells shift. A new item is taken as soon as the previous
// result has been loaded into the output register, even while it still waits there.
module singly_linked_list_manager (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op[2:0], node[7:3], ref_node[12:8], zero[15:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ok[0], node_out[5:1], node_valid[6], count[12:7]
);
    import sllm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SPREAD, S_APPLY, S_DONE} state_t;

    state_t           state_reg;
    op_t              q_op_reg;
    logic [ID_W-1:0]  q_node_reg;
    logic [ID_W-1:0]  q_ref_reg;
    cell_act_t        act_reg;
    logic [SP_W-1:0]  sp_cnt_reg;
    logic [CNT_W-1:0] count_reg;
    logic             res_ok_reg;
    logic [ID_W-1:0]  res_node_reg;
    logic             res_nvalid_reg;
    logic [CNT_W-1:0] res_count_reg;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic             out_load;

    cell_ctl_t  ctl;
    cell_data_t cell_w  [NODES];
    cell_data_t left_w  [NODES];
    cell_data_t right_w [NODES];
    logic [NODES-1:0] hit_node;
    logic [NODES-1:0] hit_ref;
    logic [NODES-1:0] tail_hot;

    genvar gi;
    generate
        for (gi = 0; gi < NODES; gi++) begin : g_cell
            if (gi == 0) begin : g_first
                assign left_w[gi] = '{valid: 1'b1, id: q_node_reg, mark: 1'b0};
            end else begin : g_mid
                assign left_w[gi] = cell_w[gi-1];
            end
            if (gi == NODES - 1) begin : g_last
                assign right_w[gi] = '{valid: 1'b0, id: '0, mark: 1'b0};
            end else begin : g_inner
                assign right_w[gi] = cell_w[gi+1];
            end
            assign tail_hot[gi] = cell_w[gi].valid && !right_w[gi].valid;

            sllm_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .q_node     (q_node_reg),
                .q_ref      (q_ref_reg),
                .left_i     (left_w[gi]),
                .right_i    (right_w[gi]),
                .cell_o     (cell_w[gi]),
                .hit_node_o (hit_node[gi]),
                .hit_ref_o  (hit_ref[gi])
            );
        end
    endgenerate

    always_comb begin
        ctl.mark_ref = (q_op_reg == OP_INSERT);
        unique case (state_reg)
            S_CHECK:  ctl.act = CA_MARK;
            S_SPREAD: ctl.act = CA_SPREAD;
            S_APPLY:  ctl.act = act_reg;
            default:  ctl.act = CA_HOLD;
        endcase
    end

    // decision taken in the check cycle
    logic            node_in;
    logic            ref_in;
    logic            nonempty;
    logic            in_pool;
    logic [ID_W-1:0] tail_id;
    logic            chk_ok;
    logic [ID_W-1:0] chk_node;
    logic            chk_nvalid;
    logic            chk_size;
    logic            chk_walk;
    cell_act_t       chk_act;

    always_comb begin
        tail_id = '0;
        for (int i = 0; i < NODES; i++) begin
            tail_id = tail_id | ({ID_W{tail_hot[i]}} & cell_w[i].id);
        end
    end

    assign node_in  = |hit_node;
    assign ref_in   = |hit_ref;
    assign nonempty = cell_w[0].valid;
    assign in_pool  = (32'(q_node_reg) < NODES);

    always_comb begin
        chk_ok     = 1'b0;
        chk_node   = '0;
        chk_nvalid = 1'b0;
        chk_size   = 1'b0;
        chk_walk   = 1'b0;
        chk_act    = CA_HOLD;
        unique case (q_op_reg)
            OP_PUSH_HEAD: begin
                chk_ok  = in_pool && !node_in;
                chk_act = CA_SHIFT_IN;
            end
            OP_PUSH_TAIL: begin
                chk_ok  = in_pool && !node_in;
                chk_act = CA_FILL;
            end
            OP_POP_HEAD: begin
                chk_ok     = nonempty;
                chk_nvalid = nonempty;
                chk_node   = nonempty ? cell_w[0].id : '0;
                chk_act    = CA_SHIFT_OUT;
            end
            OP_POP_TAIL: begin
                chk_ok     = nonempty;
                chk_nvalid = nonempty;
                chk_node   = tail_id;
                chk_act    = CA_DROP;
            end
            OP_DELETE: begin
                chk_ok   = in_pool && node_in;
                chk_walk = 1'b1;
                chk_act  = CA_CLOSE;
            end
            OP_INSERT: begin
                // node equal to ref_node is caught by node_in
                chk_ok   = in_pool && !node_in && ref_in;
                chk_walk = 1'b1;
                chk_act  = CA_OPEN;
            end
            OP_CONTAINS: begin
                chk_ok = in_pool && node_in;
            end
            OP_SIZE: begin
                chk_ok   = 1'b1;
                chk_size = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            act_reg      <= CA_HOLD;
            sp_cnt_reg   <= '0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        q_op_reg   <= op_t'(s_tdata[2:0]);
                        q_node_reg <= s_tdata[7:3];
                        q_ref_reg  <= s_tdata[12:8];
                        state_reg  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    res_ok_reg     <= chk_ok;
                    res_node_reg   <= chk_node;
                    res_nvalid_reg <= chk_nvalid;
                    res_count_reg  <= chk_size ? count_reg : '0;
                    act_reg        <= chk_ok ? chk_act : CA_HOLD;
                    sp_cnt_reg     <= SP_W'(NODES - 2);
                    state_reg      <= (chk_ok && chk_walk) ? S_SPREAD : S_APPLY;
                end
                S_SPREAD: begin
                    if (sp_cnt_reg == '0) begin
                        state_reg <= S_APPLY;
                    end else begin
                        sp_cnt_reg <= sp_cnt_reg - 1'b1;
                    end
                end
                S_APPLY: begin
                    unique case (act_reg)
                        CA_SHIFT_IN, CA_FILL, CA_OPEN:    count_reg <= count_reg + 1'b1;
                        CA_SHIFT_OUT, CA_DROP, CA_CLOSE:  count_reg <= count_reg - 1'b1;
                        default: begin
                        end
                    endcase
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        m_tdata_reg  <= {3'b000, res_count_reg, res_nvalid_reg,
                                         res_node_reg, res_ok_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/sllm_checker.sv
`timescale 1ns / 1ps

module sllm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // held result must not change until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // a returned node always means success
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tdata[0])
        else $error("node_valid without ok");

    // node_out is zero unless a node was returned
    a_node_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[6] |-> m_tdata[5:1] == 5'd0)
        else $error("node_out set without node_valid");

    // nonzero count only comes from size, which always succeeds
    a_count_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:7] != 6'd0) |-> m_tdata[0] && !m_tdata[6])
        else $error("count reported outside size request");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind singly_linked_list_manager sllm_checker u_sllm_checker (.*);

// File: tb/sv/singly_linked_list_manager_tb.sv
`timescale 1ns / 1ps

module singly_linked_list_manager_tb;
    import sllm_pkg::*;

    localparam int LIMIT     = 400000;
    localparam int PHASES    = 11;
    localparam int PHASE_LEN = 100;

    typedef struct packed {
        logic             ok;
        logic [ID_W-1:0]  node_out;
        logic             node_valid;
        logic [CNT_W-1:0] count;
    } reply_t;

    typedef struct {
        op_t    op;
        reply_t reply;
    } reply_due_t;

    typedef struct {
        op_t             op;
        logic [ID_W-1:0] nd;
        logic [ID_W-1:0] rf;
        bit              typed;
        reply_t          reply;
    } step_t;

    typedef enum {GROW, SHRINK, MIXED} mix_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [ID_W-1:0] list_q[$];   // predicted list, head first
    reply_due_t      replies_due[$];
    bit steady;
    int errors, items_sent, replies_seen, longest, pops_hit, cycles;

    singly_linked_list_manager dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[singly_linked_list_manager] ERROR");
            $finish;
        end
    end

    function automatic int locate_node(logic [ID_W-1:0] id);
        foreach (list_q[i])
            if (list_q[i] == id)
                return i;
        return -1;
    endfunction

    function automatic logic [ID_W-1:0] member_id();
        if (list_q.size() == 0)
            return ID_W'($urandom_range(NODES - 1));
        return list_q[$urandom_range(list_q.size() - 1)];
    endfunction

    // Applies one request to the predicted list and returns its result.
    function automatic reply_t apply_op(op_t op, logic [ID_W-1:0] nd, logic [ID_W-1:0] rf);
        reply_t r;
        int at;
        r = '0;
        at = -1;
        case (op)
            OP_PUSH_HEAD: begin
                if (locate_node(nd) < 0) begin
                    list_q.push_front(nd);
                    r.ok = 1'b1;
                end
            end
            OP_PUSH_TAIL: begin
                if (locate_node(nd) < 0) begin
                    list_q.push_back(nd);
                    r.ok = 1'b1;
                end
            end
            OP_POP_HEAD: begin
                if (list_q.size() != 0) begin
                    r.node_out   = list_q.pop_front();
                    r.node_valid = 1'b1;
                    r.ok         = 1'b1;
                end
            end
            OP_POP_TAIL: begin
                if (list_q.size() != 0) begin
                    r.node_out   = list_q.pop_back();
                    r.node_valid = 1'b1;
                    r.ok         = 1'b1;
                end
            end
            OP_DELETE: begin
                at = locate_node(nd);
                if (at >= 0) begin
                    list_q.delete(at);
                    r.ok = 1'b1;
                end
            end
            OP_INSERT: begin
                // node == ref_node falls out as already present
                at = locate_node(rf);
                if (locate_node(nd) < 0 && at >= 0) begin
                    list_q.insert(at, nd);
                    r.ok = 1'b1;
                end
            end
            OP_CONTAINS: begin
                r.ok = (locate_node(nd) >= 0);
            end
            OP_SIZE: begin
                r.count = CNT_W'(list_q.size());
                r.ok    = 1'b1;
            end
        endcase
        if (list_q.size() > longest)
            longest = list_q.size();
        return r;
    endfunction

    function automatic step_t mk(op_t op, int nd, int rf, bit typed, bit ok, int cnt);
        step_t s;
        s.op    = op;
        s.nd    = ID_W'(nd);
        s.rf    = ID_W'(rf);
        s.typed = typed;
        s.reply = '{ok, '0, 1'b0, CNT_W'(cnt)};
        return s;
    endfunction

    function automatic void pick_item(mix_t mix, output op_t op, output logic [ID_W-1:0] nd,
                                      output logic [ID_W-1:0] rf);
        int w[8];
        int roll;
        int k;
        case (mix)
            GROW:    w = '{25, 25, 5, 5, 8, 20, 7, 5};
            SHRINK:  w = '{8, 8, 20, 20, 20, 6, 10, 8};
            default: w = '{13, 13, 12, 12, 13, 13, 12, 12};
        endcase
        roll = $urandom_range(99);
        k = 0;
        while (roll >= w[k]) begin
            roll -= w[k];
            k++;
        end
        op = op_t'(k);
        nd = ID_W'($urandom_range(NODES - 1));
        rf = ID_W'($urandom_range(NODES - 1));
        case (op)
            OP_PUSH_HEAD, OP_PUSH_TAIL, OP_INSERT: begin
                // mostly fresh ids so the list actually fills
                if (list_q.size() < NODES && $urandom_range(99) < 75)
                    while (locate_node(nd) >= 0)
                        nd = ID_W'($urandom_range(NODES - 1));
                if (op == OP_INSERT && $urandom_range(99) < 75)
                    rf = member_id();
            end
            OP_DELETE, OP_CONTAINS: begin
                if ($urandom_range(99) < 70)
                    nd = member_id();
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(op_t op, logic [ID_W-1:0] nd, logic [ID_W-1:0] rf, bit typed,
                             reply_t typed_reply);
        reply_due_t due;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, rf, nd, op};
        do @(posedge aclk); while (!s_tready);
        due.op    = op;
        due.reply = apply_op(op, nd, rf);
        if (typed)
            due.reply = typed_reply;
        replies_due.push_back(due);
        items_sent++;
        if (!steady && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin : result_side
        reply_t     got;
        reply_due_t due;
        if (aresetn && m_tvalid && m_tready) begin
            got.ok         = m_tdata[0];
            got.node_out   = m_tdata[5:1];
            got.node_valid = m_tdata[6];
            got.count      = m_tdata[12:7];
            if (replies_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result item: got ok=%0d node_out=%0d node_valid=%0d count=%0d",
                         $time, got.ok, got.node_out, got.node_valid, got.count);
            end else begin
                due = replies_due.pop_front();
                replies_seen++;
                if (got.node_valid === 1'b1)
                    pops_hit++;
                if (got.ok !== due.reply.ok || got.node_out !== due.reply.node_out ||
                    got.node_valid !== due.reply.node_valid || got.count !== due.reply.count) begin
                    errors++;
                    $display("%0t %s: expected ok=%0d node_out=%0d node_valid=%0d count=%0d",
                             $time, due.op.name(), due.reply.ok, due.reply.node_out,
                             due.reply.node_valid, due.reply.count);
                    $display("%0t %s: actual   ok=%0d node_out=%0d node_valid=%0d count=%0d",
                             $time, due.op.name(), got.ok, got.node_out, got.node_valid, got.count);
                end
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 28);
    end

    initial begin : stimulus
        step_t           plan[$];
        mix_t            mix;
        op_t             op;
        logic [ID_W-1:0] nd;
        logic [ID_W-1:0] rf;
        plan = '{
            mk(OP_SIZE,       0,  0, 1, 1, 0),
            mk(OP_POP_HEAD,  31, 31, 1, 0, 0),
            mk(OP_POP_TAIL,   0, 31, 1, 0, 0),
            mk(OP_DELETE,     0,  0, 1, 0, 0),
            mk(OP_CONTAINS,  31,  0, 1, 0, 0),
            mk(OP_INSERT,     5,  3, 1, 0, 0),
            mk(OP_PUSH_HEAD,  0, 31, 1, 1, 0),
            mk(OP_PUSH_TAIL, 31,  0, 1, 1, 0),
            mk(OP_PUSH_HEAD,  0,  0, 1, 0, 0),
            mk(OP_PUSH_TAIL, 31, 31, 1, 0, 0),
            mk(OP_INSERT,     0,  0, 1, 0, 0),
            mk(OP_INSERT,     7,  0, 0, 0, 0),
            mk(OP_INSERT,    12, 31, 0, 0, 0),
            mk(OP_INSERT,     9, 20, 1, 0, 0),
            mk(OP_INSERT,    31,  0, 1, 0, 0),
            mk(OP_CONTAINS,  12,  0, 0, 0, 0),
            mk(OP_SIZE,      31, 31, 0, 0, 0),
            mk(OP_DELETE,    12,  0, 0, 0, 0),
            mk(OP_DELETE,     7, 31, 0, 0, 0),
            mk(OP_DELETE,    20,  0, 1, 0, 0),
            mk(OP_POP_TAIL,   0,  0, 0, 0, 0),
            mk(OP_POP_HEAD,  31, 31, 0, 0, 0),
            mk(OP_POP_TAIL,  31,  0, 1, 0, 0),
            mk(OP_SIZE,       0,  0, 1, 1, 0)
        };
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (plan[i])
            send_item(plan[i].op, plan[i].nd, plan[i].rf, plan[i].typed, plan[i].reply);
        drain();
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0, 1:    mix = GROW;
                2:       mix = MIXED;
                default: mix = SHRINK;
            endcase
            steady = (p == 4);   // one phase with no idling on either side
            repeat (PHASE_LEN) begin
                pick_item(mix, op, nd, rf);
                send_item(op, nd, rf, 1'b0, '0);
            end
            drain();
        end
        steady = 1'b0;
        repeat (40) @(posedge aclk);
        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 items_sent, replies_seen, errors);
        $display("list grew to %0d nodes, %0d pops returned a node", longest, pops_hit);
        if (errors == 0)
            $display("[singly_linked_list_manager] OK");
        else
            $display("[singly_linked_list_manager] ERROR");
        $finish;
    end

endmodule

// File: files.f
design/sllm_pkg.sv
design/sllm_cell.sv
design/singly_linked_list_manager.sv
design/sllm_checker.sv
tb/sv/singly_linked_list_manager_tb.sv
